@@ sv/segment_annulus_intersect_defines.svh @@
// Assertion macros shared by the segment and annulus intersection block.
`ifndef SEGMENT_ANNULUS_INTERSECT_DEFINES_SVH
`define SEGMENT_ANNULUS_INTERSECT_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define SAI_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked during reset as well.
`define SAI_ASSERT_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/sai_pkg.sv @@
`timescale 1ns / 1ps
// Package with widths, constants and types of the segment and annulus intersection block.
package sai_pkg;
  localparam int FRAC_BITS = 16;
  localparam int COORD_W = 32;
  localparam int RAD_W = 31;
  localparam int ROOT_W = 48;
  localparam int A_W = 2 * COORD_W + 1;
  localparam int B_W = 2 * COORD_W + 2;
  localparam int Q_W = 4 * COORD_W + 3;
  localparam int RADICAND_W = Q_W - 1;
  localparam int SQRT_W = RADICAND_W / 2;
  localparam int NUM_W = B_W + 2;
  localparam int MAG_W = NUM_W - 1 + FRAC_BITS;
  localparam int QUO_W = ROOT_W + 1;
  localparam int TOP_W = MAG_W - QUO_W;

  localparam logic [RAD_W-1:0] INNER_RESET = RAD_W'(1) << FRAC_BITS;
  localparam logic [RAD_W-1:0] OUTER_RESET = RAD_W'(50) << FRAC_BITS;
  localparam logic [ROOT_W-1:0] SENTINEL = ROOT_W'(1234) << FRAC_BITS;
  localparam logic [ROOT_W-1:0] ROOT_MAX = {1'b0, {(ROOT_W-1){1'b1}}};
  localparam logic [ROOT_W-1:0] ROOT_MIN = {1'b1, {(ROOT_W-1){1'b0}}};

  localparam logic CFG_INNER = 1'b0;
  localparam logic CFG_OUTER = 1'b1;

  typedef struct packed {
    logic [A_W-1:0] a;
    logic signed [B_W-1:0] b;
    logic signed [Q_W-1:0] q;
  } circ_t;

  typedef struct packed {
    logic [A_W-1:0] a;
    logic signed [B_W-1:0] b;
  } side_t;

  typedef struct packed {
    logic hit;
    side_t side;
    logic [SQRT_W-1:0] s;
  } sqrt_res_t;
endpackage

@@ sv/sai_if.sv @@
`timescale 1ns / 1ps
// Channel interfaces for segment items and intersection result items.
interface sai_seg_if;
  import sai_pkg::*;
  logic valid;
  logic ready;
  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;
  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface sai_res_if;
  import sai_pkg::*;
  logic valid;
  logic ready;
  logic inner_hit;
  logic signed [ROOT_W-1:0] inner_t_plus;
  logic signed [ROOT_W-1:0] inner_t_minus;
  logic outer_hit;
  logic signed [ROOT_W-1:0] outer_t_plus;
  logic signed [ROOT_W-1:0] outer_t_minus;
  modport source (output valid, inner_hit, inner_t_plus, inner_t_minus, outer_hit,
                  outer_t_plus, outer_t_minus, input ready);
  modport sink (input valid, inner_hit, inner_t_plus, inner_t_minus, outer_hit,
                outer_t_plus, outer_t_minus, output ready);
endinterface

@@ sv/sai_front.sv @@
`timescale 1ns / 1ps
// Front pipeline: quadratic coefficients and discriminant for both circles.
module sai_front (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic vin,
  input  logic signed [sai_pkg::COORD_W-1:0] start_x,
  input  logic signed [sai_pkg::COORD_W-1:0] start_y,
  input  logic signed [sai_pkg::COORD_W-1:0] end_x,
  input  logic signed [sai_pkg::COORD_W-1:0] end_y,
  input  logic [sai_pkg::RAD_W-1:0] inner_radius,
  input  logic [sai_pkg::RAD_W-1:0] outer_radius,
  output logic vout,
  output sai_pkg::circ_t inner,
  output sai_pkg::circ_t outer
);
  import sai_pkg::*;

  localparam int STAGES = 7;
  localparam int HW = COORD_W;

  logic [STAGES-1:0] vld;

  logic signed [COORD_W-1:0] x1, y1;
  logic signed [COORD_W:0] dx1, dy1;
  logic [RAD_W-1:0] ri1, ro1;

  logic [2*COORD_W-1:0] dxx2, dyy2;
  logic signed [2*COORD_W:0] bx2, by2;
  logic [2*COORD_W-2:0] xx2, yy2;
  logic [2*RAD_W-1:0] rii2, roo2;

  logic signed [A_W-1:0] ci_c, co_c;
  logic [A_W-1:0] a3;
  logic signed [B_W-1:0] b3;
  logic signed [A_W-1:0] ci3, co3;

  logic signed [B_W-1:0] babs;
  logic signed [A_W-1:0] ciabs, coabs;
  logic [A_W-1:0] a4;
  logic signed [B_W-1:0] b4;
  logic [2*HW-1:0] bm4;
  logic [2*HW-1:0] cim4, com4;
  logic cin4, con4;

  logic [A_W-1:0] a5;
  logic signed [B_W-1:0] b5;
  logic [2*HW-1:0] pbll5, pblh5, pbhh5;
  logic [2*HW:0] pill5, poll5, pilh5, polh5;
  logic [2*HW-1:0] pihl5, pohl5;
  logic [2*HW-1:0] pihh5, pohh5;
  logic cin5, con5;

  logic [A_W-1:0] a6;
  logic signed [B_W-1:0] b6;
  logic [4*HW-1:0] bb6, aci6, aco6;
  logic cin6, con6;

  logic [A_W-1:0] a7;
  logic signed [B_W-1:0] b7;
  logic signed [Q_W-1:0] qi7, qo7;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], vin};
    end
  end

  always_comb begin
    ci_c = $signed({2'b0, xx2}) + $signed({2'b0, yy2}) - $signed({3'b0, rii2});
    co_c = $signed({2'b0, xx2}) + $signed({2'b0, yy2}) - $signed({3'b0, roo2});
    babs = b3[B_W-1] ? -b3 : b3;
    ciabs = ci3[A_W-1] ? -ci3 : ci3;
    coabs = co3[A_W-1] ? -co3 : co3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= start_x;
      y1 <= start_y;
      dx1 <= (COORD_W+1)'(end_x) - (COORD_W+1)'(start_x);
      dy1 <= (COORD_W+1)'(end_y) - (COORD_W+1)'(start_y);
      ri1 <= inner_radius;
      ro1 <= outer_radius;

      dxx2 <= dx1 * dx1;
      dyy2 <= dy1 * dy1;
      bx2 <= dx1 * x1;
      by2 <= dy1 * y1;
      xx2 <= x1 * x1;
      yy2 <= y1 * y1;
      rii2 <= ri1 * ri1;
      roo2 <= ro1 * ro1;

      a3 <= A_W'(dxx2) + A_W'(dyy2);
      b3 <= B_W'(bx2) + B_W'(by2);
      ci3 <= ci_c;
      co3 <= co_c;

      a4 <= a3;
      b4 <= b3;
      bm4 <= babs[2*HW-1:0];
      cim4 <= ciabs[2*HW-1:0];
      com4 <= coabs[2*HW-1:0];
      cin4 <= ci3[A_W-1];
      con4 <= co3[A_W-1];

      a5 <= a4;
      b5 <= b4;
      pbll5 <= bm4[HW-1:0] * bm4[HW-1:0];
      pblh5 <= bm4[HW-1:0] * bm4[2*HW-1:HW];
      pbhh5 <= bm4[2*HW-1:HW] * bm4[2*HW-1:HW];
      pill5 <= a4[HW:0] * cim4[HW-1:0];
      pilh5 <= a4[HW:0] * cim4[2*HW-1:HW];
      pihl5 <= a4[A_W-1:HW+1] * cim4[HW-1:0];
      pihh5 <= a4[A_W-1:HW+1] * cim4[2*HW-1:HW];
      poll5 <= a4[HW:0] * com4[HW-1:0];
      polh5 <= a4[HW:0] * com4[2*HW-1:HW];
      pohl5 <= a4[A_W-1:HW+1] * com4[HW-1:0];
      pohh5 <= a4[A_W-1:HW+1] * com4[2*HW-1:HW];
      cin5 <= cin4;
      con5 <= con4;

      a6 <= a5;
      b6 <= b5;
      bb6 <= ((4*HW)'(pbhh5) << (2*HW)) + ((4*HW)'(pblh5) << (HW+1)) + (4*HW)'(pbll5);
      aci6 <= ((4*HW)'(pihh5) << (2*HW+1)) + ((4*HW)'(pihl5) << (HW+1))
            + ((4*HW)'(pilh5) << HW) + (4*HW)'(pill5);
      aco6 <= ((4*HW)'(pohh5) << (2*HW+1)) + ((4*HW)'(pohl5) << (HW+1))
            + ((4*HW)'(polh5) << HW) + (4*HW)'(poll5);
      cin6 <= cin5;
      con6 <= con5;

      a7 <= a6;
      b7 <= b6;
      qi7 <= cin6 ? Q_W'(bb6) + Q_W'(aci6) : Q_W'(bb6) - Q_W'(aci6);
      qo7 <= con6 ? Q_W'(bb6) + Q_W'(aco6) : Q_W'(bb6) - Q_W'(aco6);
    end
  end

  always_comb begin
    vout = vld[STAGES-1];
    inner.a = a7;
    inner.b = b7;
    inner.q = qi7;
    outer.a = a7;
    outer.b = b7;
    outer.q = qo7;
  end
endmodule

@@ sv/sai_sqrt.sv @@
`timescale 1ns / 1ps
// Pipelined floor square root of the discriminant, one root bit per stage.
module sai_sqrt (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic vin,
  input  sai_pkg::circ_t din,
  output logic vout,
  output sai_pkg::sqrt_res_t dout
);
  import sai_pkg::*;

  localparam int STAGES = SQRT_W + 1;
  localparam int REM_W = SQRT_W + 3;

  typedef struct packed {
    logic hit;
    side_t side;
    logic [RADICAND_W-1:0] rad;
    logic [REM_W-1:0] rem;
    logic [SQRT_W-1:0] root;
  } sqrt_stage_t;

  sqrt_stage_t st [STAGES];
  logic [STAGES-1:0] vld;
  logic hit_c;

  function automatic sqrt_stage_t step(sqrt_stage_t p);
    sqrt_stage_t n;
    logic [REM_W-1:0] r2;
    logic [REM_W-1:0] trial;
    n = p;
    r2 = {p.rem[REM_W-3:0], p.rad[RADICAND_W-1 -: 2]};
    trial = {1'b0, p.root, 2'b01};
    n.rad = p.rad << 2;
    if (r2 >= trial) begin
      n.rem = r2 - trial;
      n.root = {p.root[SQRT_W-2:0], 1'b1};
    end else begin
      n.rem = r2;
      n.root = {p.root[SQRT_W-2:0], 1'b0};
    end
    return n;
  endfunction

  assign hit_c = !din.q[Q_W-1] && (din.q != '0) && (din.a != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], vin};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].hit <= hit_c;
      st[0].side.a <= din.a;
      st[0].side.b <= din.b;
      st[0].rad <= hit_c ? din.q[RADICAND_W-1:0] : '0;
      st[0].rem <= '0;
      st[0].root <= '0;
      for (int k = 1; k < STAGES; k++) begin
        st[k] <= step(st[k-1]);
      end
    end
  end

  always_comb begin
    vout = vld[STAGES-1];
    dout.hit = st[STAGES-1].hit;
    dout.side = st[STAGES-1].side;
    dout.s = st[STAGES-1].root;
  end
endmodule

@@ sv/sai_div.sv @@
`timescale 1ns / 1ps
// Pipelined floor division of one root numerator, with saturation and the no-hit value.
module sai_div (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic vin,
  input  logic hit,
  input  logic signed [sai_pkg::NUM_W-1:0] num,
  input  logic [sai_pkg::A_W-1:0] a,
  output logic vout,
  output logic hit_out,
  output logic [sai_pkg::ROOT_W-1:0] root
);
  import sai_pkg::*;

  localparam int STAGES = QUO_W + 4;

  typedef struct packed {
    logic hit;
    logic neg;
    logic sat;
    logic [A_W-1:0] a;
    logic [A_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } div_stage_t;

  logic [STAGES-1:0] vld;
  logic signed [NUM_W-1:0] num_abs;
  logic hit0, neg0;
  logic [NUM_W-2:0] abs0;
  logic [A_W-1:0] a0;
  logic hit1, neg1;
  logic [MAG_W-1:0] mag1;
  logic [A_W-1:0] a1;
  div_stage_t ds [QUO_W+1];
  logic [QUO_W-1:0] q;
  logic [QUO_W-1:0] q_neg;
  logic pos_over, neg_over;

  function automatic div_stage_t step(div_stage_t p);
    div_stage_t n;
    logic [A_W:0] r2;
    logic qbit;
    n = p;
    r2 = {p.rem, p.quo[QUO_W-1]};
    qbit = r2 >= {1'b0, p.a};
    n.rem = qbit ? A_W'(r2 - {1'b0, p.a}) : r2[A_W-1:0];
    n.quo = {p.quo[QUO_W-2:0], qbit};
    return n;
  endfunction

  assign num_abs = num[NUM_W-1] ? -num : num;
  assign q = ds[QUO_W].quo;
  assign q_neg = ~q + 1'b1;
  assign pos_over = ds[QUO_W].sat || q[QUO_W-1] || q[QUO_W-2];
  assign neg_over = ds[QUO_W].sat || q[QUO_W-1] || (q[QUO_W-2] && (q[QUO_W-3:0] != '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], vin};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit0 <= hit;
      neg0 <= num[NUM_W-1];
      abs0 <= num_abs[NUM_W-2:0];
      a0 <= a;

      hit1 <= hit0;
      neg1 <= neg0;
      a1 <= a0;
      mag1 <= (MAG_W'(abs0) << FRAC_BITS) + (neg0 ? MAG_W'(a0) - MAG_W'(1) : '0);

      ds[0].hit <= hit1;
      ds[0].neg <= neg1;
      ds[0].a <= a1;
      ds[0].sat <= A_W'(mag1[MAG_W-1 -: TOP_W]) >= a1;
      ds[0].rem <= A_W'(mag1[MAG_W-1 -: TOP_W]);
      ds[0].quo <= mag1[QUO_W-1:0];
      for (int k = 1; k <= QUO_W; k++) begin
        ds[k] <= step(ds[k-1]);
      end

      hit_out <= ds[QUO_W].hit;
      if (!ds[QUO_W].hit) begin
        root <= SENTINEL;
      end else if (ds[QUO_W].neg) begin
        root <= neg_over ? ROOT_MIN : q_neg[ROOT_W-1:0];
      end else begin
        root <= pos_over ? ROOT_MAX : q[ROOT_W-1:0];
      end
    end
  end

  assign vout = vld[STAGES-1];
endmodule

@@ sv/segment_annulus_intersect.sv @@
`timescale 1ns / 1ps
// Top level of the segment against inner and outer circle intersection block.
// A segment item arrives on the seg channel and one result item leaves on the res
// channel for each segment, in order, with valid and ready handshakes on both.
// Each result gives, per circle, a hit flag and the two roots t in signed Q31.16;
// without a hit both roots read 1234.0. The user must write the circle radii through
// the cfg_we, cfg_index and cfg_data write port only while no item is in flight;
// the block does not enforce this. The datapath is a single pipeline of 127
// register stages: seven for the coefficients and discriminant, 66 for the square
// root, one for the numerators and 53 for the dividers. One segment is accepted
// every cycle unless a waiting result is held off by the receiver.
// When the receiver holds off ready while a result waits, the whole pipeline
// holds and seg.ready drops in the same cycle; no item is lost or repeated.
// Reset clears all valid bits and loads the radii with 1.0 and 50.0.
`include "segment_annulus_intersect_defines.svh"
module segment_annulus_intersect (
  input  logic clk,
  input  logic rst,
  sai_seg_if.sink seg,
  sai_res_if.source res,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [sai_pkg::RAD_W-1:0] cfg_data
);
  import sai_pkg::*;

  logic [RAD_W-1:0] inner_radius, outer_radius;
  logic en;
  logic v_front, v_sqrt, v_num;
  circ_t c_inner, c_outer;
  sqrt_res_t s_inner, s_outer;
  logic signed [NUM_W-1:0] nbi_c, nbo_c, npi_c, nmi_c, npo_c, nmo_c;
  logic hit_i, hit_o;
  logic [A_W-1:0] a_i, a_o;
  logic signed [NUM_W-1:0] np_i, nm_i, np_o, nm_o;
  logic [ROOT_W-1:0] tpi, tmi, tpo, tmo;

  assign en = !res.valid || res.ready;
  assign seg.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_radius <= INNER_RESET;
      outer_radius <= OUTER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INNER: inner_radius <= cfg_data;
        CFG_OUTER: outer_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  sai_front u_front (
    .clk(clk), .rst(rst), .en(en), .vin(seg.valid && seg.ready),
    .start_x(seg.start_x), .start_y(seg.start_y), .end_x(seg.end_x), .end_y(seg.end_y),
    .inner_radius(inner_radius), .outer_radius(outer_radius),
    .vout(v_front), .inner(c_inner), .outer(c_outer)
  );

  sai_sqrt u_sqrt_inner (
    .clk(clk), .rst(rst), .en(en), .vin(v_front), .din(c_inner),
    .vout(v_sqrt), .dout(s_inner)
  );

  sai_sqrt u_sqrt_outer (
    .clk(clk), .rst(rst), .en(en), .vin(v_front), .din(c_outer),
    .vout(), .dout(s_outer)
  );

  always_comb begin
    nbi_c = -NUM_W'($signed(s_inner.side.b));
    nbo_c = -NUM_W'($signed(s_outer.side.b));
    npi_c = nbi_c + $signed(NUM_W'(s_inner.s));
    nmi_c = nbi_c - $signed(NUM_W'(s_inner.s));
    npo_c = nbo_c + $signed(NUM_W'(s_outer.s));
    nmo_c = nbo_c - $signed(NUM_W'(s_outer.s));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_num <= 1'b0;
    end else if (en) begin
      v_num <= v_sqrt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_i <= s_inner.hit;
      hit_o <= s_outer.hit;
      a_i <= s_inner.side.a;
      a_o <= s_outer.side.a;
      np_i <= npi_c;
      nm_i <= nmi_c;
      np_o <= npo_c;
      nm_o <= nmo_c;
    end
  end

  sai_div u_div_ip (
    .clk(clk), .rst(rst), .en(en), .vin(v_num), .hit(hit_i), .num(np_i), .a(a_i),
    .vout(res.valid), .hit_out(res.inner_hit), .root(tpi)
  );

  sai_div u_div_im (
    .clk(clk), .rst(rst), .en(en), .vin(v_num), .hit(hit_i), .num(nm_i), .a(a_i),
    .vout(), .hit_out(), .root(tmi)
  );

  sai_div u_div_op (
    .clk(clk), .rst(rst), .en(en), .vin(v_num), .hit(hit_o), .num(np_o), .a(a_o),
    .vout(), .hit_out(res.outer_hit), .root(tpo)
  );

  sai_div u_div_om (
    .clk(clk), .rst(rst), .en(en), .vin(v_num), .hit(hit_o), .num(nm_o), .a(a_o),
    .vout(), .hit_out(), .root(tmo)
  );

  assign res.inner_t_plus = tpi;
  assign res.inner_t_minus = tmi;
  assign res.outer_t_plus = tpo;
  assign res.outer_t_minus = tmo;

  `SAI_ASSERT_SAME(a_inner_miss, clk, rst, res.valid && !res.inner_hit, (res.inner_t_plus == SENTINEL) && (res.inner_t_minus == SENTINEL), "Inner miss without sentinel roots.")
  `SAI_ASSERT_SAME(a_outer_miss, clk, rst, res.valid && !res.outer_hit, (res.outer_t_plus == SENTINEL) && (res.outer_t_minus == SENTINEL), "Outer miss without sentinel roots.")
  `SAI_ASSERT_SAME(a_root_order, clk, rst, res.valid && res.inner_hit && res.outer_hit, ($signed(res.inner_t_plus) >= $signed(res.inner_t_minus)) && ($signed(res.outer_t_plus) >= $signed(res.outer_t_minus)), "Plus root below minus root.")
  `SAI_ASSERT_NEXT(a_reset_empty, clk, rst, !res.valid, "Result valid right after reset.")
endmodule
